// File: design/bmwf_pkg.sv
`timescale 1ns / 1ps

package bmwf_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPERATION    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_FIVE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_PIXEL = 3'd4;

   localparam logic [10:0] RESET_IMAGE_WIDTH  = 11'd320;
   localparam logic [10:0] RESET_IMAGE_HEIGHT = 11'd240;

   // operation codes
   localparam logic [1:0] OP_DILATION = 2'd0;
   localparam logic [1:0] OP_OPENING  = 2'd2;
   localparam logic [1:0] OP_CLOSING  = 2'd3;

   localparam logic [7:0] PIXEL_ON  = 8'hFF;
   localparam logic [7:0] PIXEL_OFF = 8'h00;

   // bit 1: pixel equals 255, bit 0: pixel equals 0
   typedef logic [1:0] flag_pair_type;

   // four older rows of one column
   typedef flag_pair_type [3:0] col_hist_type;

   // [age][row], age 0 and row 0 newest
   typedef flag_pair_type [4:0][4:0] window_type;

endpackage

// File: design/binary_morphology_window_filter_core.sv
`timescale 1ns / 1ps

// binary morphology window filter: dilation, erosion, opening or closing of a
// raster-order 0/255 mask over a 3x3 or 5x5 square window
// req channel: one beat per pixel; tuser = action (0 pixel, 1 drain), tdata = pixel
// the first pixel beat while no frame is open latches operation, window size and
// image size; border_pixel is used as it stands
// rsp channel: one beat per filtered pixel in raster order, tlast on the last of a frame
// with radius R (1 or 2), width W and P passes, result k leaves on the item that
// brings pixel k + P*(R*W+R); once all pixels are in, each further item (drain or
// pixel) releases one result; drains before that are dropped
// when the image is smaller than that delay, tready stays low for P*(R*W+R) - W*H
// pipe steps after the last pixel (one a cycle unless rsp stalls) over the border
// throughput: one item per cycle unless rsp stalls; an accepted item passes through three pipe
// stages and the output register before its rsp beat; the line stores are single-port
// write / single-port read per pass, one read and one write per cycle
// the whole pipe stalls only when a result waits in the output register and
// rsp_tready is low
// reset (synchronous) clears control state, configuration and valid bits; line stores are not
// cleared, stale rows are masked by the image bounds

module binary_morphology_window_filter_core
   import bmwf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // req beat
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] pixel
   input  logic                   req_tuser,   // [0] action
   // rsp beat
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] out_pixel
   output logic                   rsp_tlast,   // frame_end
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);    // column index
   localparam int WW = CW + 1;                // width value
   localparam int HW = $clog2(MAX_HEIGHT) + 1;// height value
   localparam int RW = HW + 1;                // row index, runs past the image on flush
   localparam int LW = WW + 2;                // pass delay counters

   typedef struct packed {
      logic [WW-1:0] w;
      logic [HW-1:0] h;
      logic          five;
      logic [1:0]    op;
   } frame_cfg_type;

   typedef struct packed {
      logic          valid;
      logic          qv;
      logic          kv;
      logic          last;
      logic [CW-1:0] col1;
      logic [CW-1:0] col2;
      logic [RW-1:0] row2;
      logic [CW-1:0] colo;
      logic [RW-1:0] rowo;
      frame_cfg_type fc;
      flag_pair_type pix;
   } stage1_type;

   typedef struct packed {
      logic          valid;
      logic          qv;
      logic          kv;
      logic          last;
      logic [CW-1:0] col2;
      logic [RW-1:0] row2;
      logic [CW-1:0] colo;
      logic [RW-1:0] rowo;
      frame_cfg_type fc;
   } stage2_type;

   typedef struct packed {
      logic          valid;
      logic          kv;
      logic          last;
      logic          r1;
      logic [CW-1:0] colo;
      logic [RW-1:0] rowo;
      frame_cfg_type fc;
   } stage3_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [1:0]  op_ff;
   logic        five_ff;
   logic [10:0] width_ff;
   logic [10:0] height_ff;
   logic [7:0]  border_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_DILATION;
         five_ff   <= 1'b0;
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         border_ff <= PIXEL_OFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPERATION:    op_ff     <= csr_wdata[1:0];
            CSR_WINDOW_FIVE:  five_ff   <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[10:0];
            CSR_BORDER_PIXEL: border_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // zero counts as one, oversize saturates
   logic [WW-1:0] w_clamp;
   logic [HW-1:0] h_clamp;

   always_comb begin
      if (width_ff == 11'd0)
         w_clamp = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         w_clamp = WW'(MAX_WIDTH);
      else
         w_clamp = WW'(width_ff);
      if (height_ff == 11'd0)
         h_clamp = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT)
         h_clamp = HW'(MAX_HEIGHT);
      else
         h_clamp = HW'(height_ff);
   end

   logic b255, b0;
   assign b255 = (border_ff == PIXEL_ON);
   assign b0   = (border_ff == PIXEL_OFF);

   // ---------------------------------------------------------------
   // window evaluation: any 255 for dilation, any 0 for erosion
   // ---------------------------------------------------------------
   function automatic logic morph_eval(input window_type win, input logic [RW-1:0] row,
                                       input logic [CW-1:0] col, input frame_cfg_type fc,
                                       input logic dil, input logic bd255, input logic bd0);
      logic [4:0]             row_ok;
      logic [4:0]             col_ok;
      logic [4:0]             in_win;
      logic signed [RW+1:0]   rr;
      logic signed [WW+1:0]   cc;
      logic                   hit255;
      logic                   hit0;
      hit255 = 1'b0;
      hit0   = 1'b0;
      for (int k = 0; k < 5; k++) begin
         rr = $signed({2'b00, row}) + $signed((RW+2)'(fc.five ? 2 : 1))
              - $signed((RW+2)'(k));
         cc = $signed({3'b000, col}) + $signed((WW+2)'(fc.five ? 2 : 1))
              - $signed((WW+2)'(k));
         row_ok[k] = (rr >= 0) && (rr < $signed({3'b000, fc.h}));
         col_ok[k] = (cc >= 0) && (cc < $signed({2'b00, fc.w}));
         in_win[k] = fc.five || (k < 3);
      end
      for (int j = 0; j < 5; j++) begin
         for (int i = 0; i < 5; i++) begin
            if (in_win[j] && in_win[i]) begin
               if (row_ok[i] && col_ok[j]) begin
                  hit255 = hit255 | win[j][i][1];
                  hit0   = hit0 | win[j][i][0];
               end else begin
                  hit255 = hit255 | bd255;
                  hit0   = hit0 | bd0;
               end
            end
         end
      end
      return dil ? hit255 : ~hit0;
   endfunction

   // ---------------------------------------------------------------
   // front: frame tracking and stream position counters
   // ---------------------------------------------------------------
   logic          adv;
   logic          rsp_valid_ff;

   logic          active_ff, done_ff;
   frame_cfg_type cfg_ff;
   logic [CW-1:0] col1_ff, col2_ff, colo_ff;
   logic [RW-1:0] row1_ff, row2_ff, rowo_ff;
   logic [LW-1:0] lag1_ff, lag2_ff;

   logic          two_now, kv_now, hold_in, acc, start, tick;
   frame_cfg_type cfg_new, cfg_e;
   logic [LW-1:0] d1_new, lag1_e, lag2_e, lag1_in, lag2_in;
   logic [CW-1:0] col1_e, col2_e, colo_e, col1_in, col2_in, colo_in;
   logic [RW-1:0] row1_e, row2_e, rowo_e, row1_in, row2_in, rowo_in;
   logic          done_e, done_in, qv, kv, two_e, end1, end2, endo, last_pix, last_out;

   // pipe only stops while a result waits unclaimed
   assign adv = !rsp_valid_ff || rsp_tready;

   assign two_now = (cfg_ff.op == OP_OPENING) || (cfg_ff.op == OP_CLOSING);
   assign kv_now  = two_now ? ((lag1_ff == '0) && (lag2_ff == '0)) : (lag1_ff == '0);
   // after the last pixel, border positions that give no result run on their own
   assign hold_in = active_ff && done_ff && !kv_now;

   assign req_tready = adv && !hold_in;
   assign acc        = req_tvalid && req_tready;
   assign start      = acc && !req_tuser && !active_ff;
   assign tick       = (acc && (start || (active_ff && (done_ff || !req_tuser))))
                       || (adv && hold_in);

   always_comb begin
      cfg_new.w    = w_clamp;
      cfg_new.h    = h_clamp;
      cfg_new.five = five_ff;
      cfg_new.op   = op_ff;
      d1_new = five_ff ? ((LW'(w_clamp) << 1) + LW'(2)) : (LW'(w_clamp) + LW'(1));
   end

   assign cfg_e  = start ? cfg_new : cfg_ff;
   assign lag1_e = start ? d1_new : lag1_ff;
   assign lag2_e = start ? d1_new : lag2_ff;
   assign col1_e = start ? '0 : col1_ff;
   assign row1_e = start ? '0 : row1_ff;
   assign col2_e = start ? '0 : col2_ff;
   assign row2_e = start ? '0 : row2_ff;
   assign colo_e = start ? '0 : colo_ff;
   assign rowo_e = start ? '0 : rowo_ff;
   assign done_e = start ? 1'b0 : done_ff;

   assign two_e = (cfg_e.op == OP_OPENING) || (cfg_e.op == OP_CLOSING);
   assign qv    = (lag1_e == '0);
   assign kv    = two_e ? (qv && (lag2_e == '0)) : qv;

   assign end1 = (WW'(col1_e) == cfg_e.w - 1'b1);
   assign end2 = (WW'(col2_e) == cfg_e.w - 1'b1);
   assign endo = (WW'(colo_e) == cfg_e.w - 1'b1);

   assign last_pix = !done_e && end1 && (row1_e == RW'(cfg_e.h - 1'b1));
   assign last_out = kv && endo && (rowo_e == RW'(cfg_e.h - 1'b1));

   always_comb begin
      col1_in = end1 ? '0 : col1_e + 1'b1;
      row1_in = end1 ? row1_e + 1'b1 : row1_e;
      done_in = done_e || last_pix;
      lag1_in = qv ? lag1_e : lag1_e - 1'b1;
      lag2_in = (qv && (lag2_e != '0)) ? lag2_e - 1'b1 : lag2_e;
      col2_in = col2_e;
      row2_in = row2_e;
      if (qv) begin
         col2_in = end2 ? '0 : col2_e + 1'b1;
         row2_in = end2 ? row2_e + 1'b1 : row2_e;
      end
      colo_in = colo_e;
      rowo_in = rowo_e;
      if (kv) begin
         colo_in = endo ? '0 : colo_e + 1'b1;
         rowo_in = endo ? rowo_e + 1'b1 : rowo_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cfg_ff    <= '0;
         col1_ff   <= '0;
         row1_ff   <= '0;
         col2_ff   <= '0;
         row2_ff   <= '0;
         colo_ff   <= '0;
         rowo_ff   <= '0;
         lag1_ff   <= '0;
         lag2_ff   <= '0;
      end else if (tick) begin
         active_ff <= !last_out;
         done_ff   <= done_in;
         cfg_ff    <= cfg_e;
         col1_ff   <= col1_in;
         row1_ff   <= row1_in;
         col2_ff   <= col2_in;
         row2_ff   <= row2_in;
         colo_ff   <= colo_in;
         rowo_ff   <= rowo_in;
         lag1_ff   <= lag1_in;
         lag2_ff   <= lag2_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: first line store read, first window shift
   // ---------------------------------------------------------------
   stage1_type s1_ff, s1_in;

   always_comb begin
      s1_in.valid = tick;
      s1_in.qv    = qv;
      s1_in.kv    = kv;
      s1_in.last  = last_out;
      s1_in.col1  = col1_e;
      s1_in.col2  = col2_e;
      s1_in.row2  = row2_e;
      s1_in.colo  = colo_e;
      s1_in.rowo  = rowo_e;
      s1_in.fc    = cfg_e;
      s1_in.pix   = {req_tdata == PIXEL_ON, req_tdata == PIXEL_OFF};
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_ff.valid <= 1'b0;
      else if (adv)
         s1_ff.valid <= s1_in.valid;
      if (adv) begin
         s1_ff.qv   <= s1_in.qv;
         s1_ff.kv   <= s1_in.kv;
         s1_ff.last <= s1_in.last;
         s1_ff.col1 <= s1_in.col1;
         s1_ff.col2 <= s1_in.col2;
         s1_ff.row2 <= s1_in.row2;
         s1_ff.colo <= s1_in.colo;
         s1_ff.rowo <= s1_in.rowo;
         s1_ff.fc   <= s1_in.fc;
         s1_ff.pix  <= s1_in.pix;
      end
   end

   col_hist_type mem1 [MAX_WIDTH];
   col_hist_type rd1_ff;
   col_hist_type wd1;
   logic         we1;

   assign we1 = adv && s1_ff.valid;
   assign wd1 = {rd1_ff[2:0], s1_ff.pix};

   // one write and one read per cycle; same column back to back forwards
   always_ff @(posedge clock) begin
      if (we1)
         mem1[s1_ff.col1] <= wd1;
      if (adv) begin
         if (we1 && (s1_ff.col1 == col1_e))
            rd1_ff <= wd1;
         else
            rd1_ff <= mem1[col1_e];
      end
   end

   window_type win1_ff;

   always_ff @(posedge clock) begin
      if (we1) begin
         win1_ff[0]   <= {rd1_ff, s1_ff.pix};
         win1_ff[4:1] <= win1_ff[3:0];
      end
   end

   // ---------------------------------------------------------------
   // stage 2: first pass result, second line store, second window shift
   // ---------------------------------------------------------------
   stage2_type s2_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_ff.valid <= 1'b0;
      else if (adv)
         s2_ff.valid <= s1_ff.valid;
      if (adv) begin
         s2_ff.qv   <= s1_ff.qv;
         s2_ff.kv   <= s1_ff.kv;
         s2_ff.last <= s1_ff.last;
         s2_ff.col2 <= s1_ff.col2;
         s2_ff.row2 <= s1_ff.row2;
         s2_ff.colo <= s1_ff.colo;
         s2_ff.rowo <= s1_ff.rowo;
         s2_ff.fc   <= s1_ff.fc;
      end
   end

   logic dil1, r1;

   assign dil1 = (s2_ff.fc.op == OP_DILATION) || (s2_ff.fc.op == OP_CLOSING);
   assign r1   = morph_eval(win1_ff, s2_ff.row2, s2_ff.col2, s2_ff.fc, dil1, b255, b0);

   logic [3:0] mem2 [MAX_WIDTH];
   logic [3:0] rd2_ff;
   logic [3:0] wd2;
   logic       we2;

   assign we2 = adv && s2_ff.valid && s2_ff.qv;
   assign wd2 = {rd2_ff[2:0], r1};

   always_ff @(posedge clock) begin
      if (we2)
         mem2[s2_ff.col2] <= wd2;
      if (adv) begin
         if (we2 && (s2_ff.col2 == s1_ff.col2))
            rd2_ff <= wd2;
         else
            rd2_ff <= mem2[s1_ff.col2];
      end
   end

   // intermediate image is strictly 0 or 255
   logic [4:0][4:0] win2_ff;

   always_ff @(posedge clock) begin
      if (we2) begin
         win2_ff[0]   <= {rd2_ff, r1};
         win2_ff[4:1] <= win2_ff[3:0];
      end
   end

   // ---------------------------------------------------------------
   // stage 3: second pass result and output select
   // ---------------------------------------------------------------
   stage3_type s3_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s3_ff.valid <= 1'b0;
      else if (adv)
         s3_ff.valid <= s2_ff.valid;
      if (adv) begin
         s3_ff.kv   <= s2_ff.kv;
         s3_ff.last <= s2_ff.last;
         s3_ff.r1   <= r1;
         s3_ff.colo <= s2_ff.colo;
         s3_ff.rowo <= s2_ff.rowo;
         s3_ff.fc   <= s2_ff.fc;
      end
   end

   window_type win2_flags;

   always_comb begin
      for (int j = 0; j < 5; j++) begin
         for (int i = 0; i < 5; i++) begin
            win2_flags[j][i] = {win2_ff[j][i], ~win2_ff[j][i]};
         end
      end
   end

   logic two3, dil2, r2, res;

   assign two3 = (s3_ff.fc.op == OP_OPENING) || (s3_ff.fc.op == OP_CLOSING);
   assign dil2 = (s3_ff.fc.op == OP_OPENING);
   assign r2   = morph_eval(win2_flags, s3_ff.rowo, s3_ff.colo, s3_ff.fc, dil2, b255, b0);
   assign res  = two3 ? r2 : s3_ff.r1;

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= s3_ff.valid && s3_ff.kv;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= res ? PIXEL_ON : PIXEL_OFF;
         rsp_last_ff <= s3_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
